### hw/rtl/spfp_pkg.sv
// Shared types, constants and the word-write function for the sample packer.
// No dependencies; used by every module of the block.
package spfp_pkg;

	localparam int SAMPLE_W = 10;
	localparam int ACC_W = 32;
	localparam int WORD_W = 16;
	localparam int OFF_W = 8;
	localparam int GROUP_SIZE = 3;
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W = 3;

	localparam logic [WORD_W-1:0] FLASH_LIMIT = 16'd28672;
	localparam logic [OFF_W-1:0] PAGE_BYTES = 8'd128;
	localparam logic [OFF_W-1:0] OFF_STEP = 8'd2;
	localparam logic [WORD_W-1:0] BASE_MAX = 16'hffff;

	typedef enum logic [1:0] {
		KIND_FILL   = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_OOM    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [WORD_W-1:0]  address;
		logic [WORD_W-1:0]  data_word;
		logic               last;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] result_list_t;

	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [1:0]         cnt;
		logic [WORD_W-1:0]  base;
		logic [OFF_W-1:0]   off;
		logic               halted;
	} state_t;

	typedef struct packed {
		result_t [1:0]      res;
		logic [1:0]         n;
		logic               halt;
		logic [WORD_W-1:0]  base;
		logic [OFF_W-1:0]   off;
	} wr_t;

	// One flash word write: fill, optional page commit, or out of memory.
	function automatic wr_t write_word(logic [WORD_W-1:0] base, logic [OFF_W-1:0] off,
			logic [WORD_W-1:0] word);
		wr_t w;
		logic [OFF_W-1:0] off_n;
		logic [WORD_W:0] sum;
		w = '0;
		off_n = off + OFF_STEP;
		sum = {1'b0, base} + {{(WORD_W+1-OFF_W){1'b0}}, PAGE_BYTES};
		w.base = base;
		w.off = off;
		if (base >= FLASH_LIMIT) begin
			w.res[0] = '{kind: KIND_OOM, address: '0, data_word: '0, last: 1'b0};
			w.n = 2'd1;
			w.halt = 1'b1;
		end else begin
			w.res[0] = '{kind: KIND_FILL,
				address: base + {{(WORD_W-OFF_W){1'b0}}, off},
				data_word: word, last: 1'b0};
			w.n = 2'd1;
			w.off = off_n;
			if (off_n >= PAGE_BYTES) begin
				w.res[1] = '{kind: KIND_COMMIT, address: base, data_word: '0, last: 1'b0};
				w.n = 2'd2;
				w.base = sum[WORD_W] ? BASE_MAX : sum[WORD_W-1:0];
				w.off = '0;
			end
		end
		return w;
	endfunction

endpackage

### hw/rtl/spfp_step.sv
// Combinational next-state and result-list logic for one sample.
// Depends on spfp_pkg.
module spfp_step (
	input  spfp_pkg::state_t                  cur,
	input  logic [spfp_pkg::SAMPLE_W-1:0]     sample,
	output spfp_pkg::state_t                  nxt,
	output spfp_pkg::result_list_t            res,
	output logic [spfp_pkg::CNT_W-1:0]        n
);

	spfp_pkg::wr_t w0;
	spfp_pkg::wr_t w1;
	logic [1:0] last_idx;

	always_comb begin
		nxt = cur;
		res = '0;
		n = '0;
		w0 = '0;
		w1 = '0;
		last_idx = '0;
		if (cur.halted) begin
			res[0] = '{kind: spfp_pkg::KIND_OOM, address: '0, data_word: '0, last: 1'b1};
			n = spfp_pkg::CNT_W'(1);
		end else begin
			nxt.acc = {cur.acc[spfp_pkg::ACC_W-spfp_pkg::SAMPLE_W-1:0], sample};
			if (cur.cnt == 2'(spfp_pkg::GROUP_SIZE - 1)) begin
				nxt.cnt = '0;
				w0 = spfp_pkg::write_word(cur.base, cur.off, nxt.acc[15:0]);
				res[1:0] = w0.res;
				n = {1'b0, w0.n};
				if (w0.halt) begin
					nxt.halted = 1'b1;
				end else begin
					w1 = spfp_pkg::write_word(w0.base, w0.off, nxt.acc[31:16]);
					if (w0.n == 2'd1) begin
						res[2:1] = w1.res;
					end else begin
						res[3:2] = w1.res;
					end
					n = {1'b0, w0.n} + {1'b0, w1.n};
					nxt.base = w1.base;
					nxt.off = w1.off;
					nxt.halted = w1.halt;
				end
				last_idx = 2'(n - spfp_pkg::CNT_W'(1));
				res[last_idx].last = 1'b1;
			end else begin
				nxt.cnt = cur.cnt + 2'd1;
			end
		end
	end

endmodule

### hw/rtl/spfp_emit.sv
// Result buffer: holds the results of one sample and issues them one per cycle while the output is not stalled.
// Depends on spfp_pkg.
module spfp_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  spfp_pkg::result_list_t            res,
	input  logic [spfp_pkg::CNT_W-1:0]        n,
	input  logic                              out_stall,
	output logic                              out_valid,
	output spfp_pkg::result_t                 out_res,
	output logic                              free
);

	spfp_pkg::result_list_t entries_q;
	logic [spfp_pkg::CNT_W-1:0] cnt_q;
	logic [spfp_pkg::CNT_W-1:0] idx_q;
	logic [spfp_pkg::CNT_W-1:0] remaining;
	logic out_take;

	assign remaining = cnt_q - idx_q;
	assign out_valid = (remaining != '0);
	assign out_res = entries_q[idx_q[1:0]];
	assign out_take = out_valid && !out_stall;
	assign free = (remaining == '0) || (remaining == spfp_pkg::CNT_W'(1) && out_take);

	always_ff @(posedge clk) begin
		if (load) begin
			entries_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= n;
			idx_q <= '0;
		end else if (out_take) begin
			idx_q <= idx_q + spfp_pkg::CNT_W'(1);
		end
	end

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.last == (remaining == spfp_pkg::CNT_W'(1))))
		else $error("last flag does not match final buffered result");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q && cnt_q <= spfp_pkg::CNT_W'(spfp_pkg::MAX_RESULTS))
		else $error("result index out of range");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("buffer loaded while results pending");

endmodule

### hw/rtl/sample_packer_flash_pages_core.sv
// Top level of the ten-bit sample packer with flash page writes.
// Depends on spfp_pkg, spfp_step and spfp_emit.
//
// A sample is accepted into an input register in any cycle the register is
// empty or is moving on; from there one combinational pass updates the packer
// state and loads its results (none; two or three fills and commits, possibly
// ending in an out-of-memory; or a lone out-of-memory) into the result buffer,
// which issues one result per cycle while the output is not stalled. While not
// halted, a sample that does not close a group loads no results and leaves the
// buffer free; a group-closing sample holds the buffer until its results are
// taken, while the input register can take the next sample. The first result
// passes through the input register and then the result buffer before it is
// presented; a buffer that is not free holds the sample in the input register.
module sample_packer_flash_pages_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [spfp_pkg::SAMPLE_W-1:0]     sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic [spfp_pkg::WORD_W-1:0]       address,
	output logic [spfp_pkg::WORD_W-1:0]       data_word,
	output logic                              last
);

	logic valid_s1;
	logic [spfp_pkg::SAMPLE_W-1:0] sample_s1;
	spfp_pkg::state_t st_q;
	spfp_pkg::state_t st_nxt;
	spfp_pkg::result_list_t res;
	logic [spfp_pkg::CNT_W-1:0] n;
	spfp_pkg::result_t out_res;
	logic free;
	logic load;
	logic in_take;

	assign load = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				st_q <= st_nxt;
			end
		end
	end

	spfp_step u_step (
		.cur    (st_q),
		.sample (sample_s1),
		.nxt    (st_nxt),
		.res    (res),
		.n      (n)
	);

	spfp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.n         (n),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.free      (free)
	);

	assign kind = out_res.kind;
	assign address = out_res.address;
	assign data_word = out_res.data_word;
	assign last = out_res.last;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |=> st_q.halted)
		else $error("halted state cleared");
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.off[0] && st_q.off < spfp_pkg::PAGE_BYTES)
		else $error("page offset out of range");
	a_halt_oom: assert property (@(posedge clk) disable iff (!arst_n)
		load && st_q.halted |=> out_valid && kind == spfp_pkg::KIND_OOM && last)
		else $error("halted block issued a non out-of-memory result");

endmodule
